/* rtl/lbp_3x3_border_modes_defines.svh */
// Assertion macros for the local binary pattern block.
`ifndef LBP_3X3_BORDER_MODES_DEFINES_SVH
`define LBP_3X3_BORDER_MODES_DEFINES_SVH

`ifndef SYNTH
`define LBP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LBP_ASSERT(label, clk, rst, prop, msg)
`define LBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/lbp_pkg.sv */
package lbp_pkg;

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd2;

  localparam logic [1:0] MODE_CROP      = 2'd0;
  localparam logic [1:0] MODE_PAD_LOW   = 2'd1;
  localparam logic [1:0] MODE_PAD_HIGH  = 2'd2;
  localparam logic [1:0] MODE_REPLICATE = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam int         CODE_BITS = 8;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Ring order, clockwise from top-left, in row-major window positions.
  localparam logic [3:0] RING_POS [CODE_BITS] = '{4'd0, 4'd1, 4'd2, 4'd5,
                                                  4'd8, 4'd7, 4'd6, 4'd3};

  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last_of_frame;
  } oq_item_t;

  typedef struct packed {
    logic     first_v;
    logic     second_v;
    oq_item_t first;
    oq_item_t second;
  } oq_push_t;

  function automatic logic [7:0] lbp_code(input win_t win, input logic [1:0] mode,
                                          input logic mt, input logic mb,
                                          input logic ml, input logic mr);
    win_t       n;
    logic [7:0] padv;
    logic [7:0] res;
    n    = win;
    padv = (mode == MODE_PAD_HIGH) ? PIX_MAX : 8'd0;
    if (mode == MODE_REPLICATE) begin
      for (int k = 0; k < 3; k++) begin
        if (mt) n[k] = n[3 + k];
        if (mb) n[6 + k] = n[3 + k];
      end
      for (int k = 0; k < 3; k++) begin
        if (ml) n[k * 3] = n[k * 3 + 1];
        if (mr) n[k * 3 + 2] = n[k * 3 + 1];
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (mt) n[k] = padv;
        if (mb) n[6 + k] = padv;
        if (ml) n[k * 3] = padv;
        if (mr) n[k * 3 + 2] = padv;
      end
    end
    for (int k = 0; k < CODE_BITS; k++) begin
      res[CODE_BITS - 1 - k] = (n[RING_POS[k]] >= n[4]);
    end
    return res;
  endfunction

endpackage

/* rtl/lbp_ifs.sv */
interface lbp_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel;
  modport source (output valid, output req_type, output pixel, input ready);
  modport sink (input valid, input req_type, input pixel, output ready);
endinterface

interface lbp_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code;
  logic       last_of_frame;
  modport source (output valid, output code, output last_of_frame, input ready);
  modport sink (input valid, input code, input last_of_frame, output ready);
endinterface

interface lbp_cfg_if import lbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/lbp_ram.sv */
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lbp_outq.sv */
module lbp_outq
  import lbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  oq_push_t         push,
  lbp_code_if.source       q_out,
  output logic [OQ_CW-1:0] count
);

  oq_item_t         mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             pop;
  logic [OQ_CW-1:0] count_next;

  assign q_out.valid         = (count != '0);
  assign q_out.code          = mem[rd_ptr].code;
  assign q_out.last_of_frame = mem[rd_ptr].last_of_frame;
  assign pop                 = q_out.valid & q_out.ready;

  always_comb begin
    count_next = count + OQ_CW'(push.first_v) + OQ_CW'(push.second_v) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + OQ_AW'(push.first_v) + OQ_AW'(push.second_v);
      if (pop) rd_ptr <= rd_ptr + OQ_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_v) mem[wr_ptr] <= push.first;
    if (push.second_v) mem[wr_ptr + OQ_AW'(1)] <= push.second;
  end

endmodule

/* rtl/lbp_3x3_border_modes.sv */
// Codes, the extra last-column code too, pass register stage s1 and an 8-entry output queue.
// Throughput: one pixel per cycle unless the queue lacks room or a column fill is running.
// Outside crop mode the first flush after a frame waits through ST_LEFT and ST_CENTER
// while two line-buffer columns are read; later flushes go through the single read port.
// Reset clears counters, window, queue and sets width 640, height 480, crop mode;
// line buffers are not cleared.
`include "lbp_3x3_border_modes_defines.svh"
module lbp_3x3_border_modes
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  lbp_cfg_if.sink    cfg,
  lbp_pix_if.sink    pix_in,
  lbp_code_if.source code_out
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = (CW > CFG_WIDTH_W) ? CW : CFG_WIDTH_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LEFT   = 3'b010,
    ST_CENTER = 3'b100
  } fill_state_t;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [1:0]              border_mode;

  logic [AW-1:0]           col_cnt;
  logic [CFG_HEIGHT_W-1:0] row_cnt;
  logic [CW-1:0]           drain_cnt;
  fill_state_t             st;
  fill_state_t             st_next;
  logic [CW-1:0]           load_cc;
  logic                    dwin_valid;
  logic [CW-1:0]           dwin_cc;

  logic [WW-1:0]           iw_ext;
  logic [CW-1:0]           w;
  logic [CFG_HEIGHT_W-1:0] h;
  logic [AW-1:0]           c;
  logic [CFG_HEIGHT_W-1:0] r;
  logic                    lastc;
  logic                    lastr;
  logic [CW-1:0]           dc_clamp;
  logic [CW-1:0]           cc_full;
  logic [CW-1:0]           cc_plus;
  logic [CW-1:0]           cc_minus;
  logic                    ml_f;
  logic                    mr_f;
  logic                    is_flush;
  logic                    drain_active;
  logic                    win_hit;
  logic                    need_fill;
  logic                    start_fill;
  logic [OQ_CW:0]          occ;
  logic                    room;
  logic                    acc;
  logic [AW-1:0]           rd_addr;

  logic s0_em1, s0_em2, s0_mt, s0_ml, s0_ml2, s0_mr, s0_last;

  logic                    s1_valid;
  logic                    s1_is_pix;
  logic [AW-1:0]           s1_c;
  logic [7:0]              s1_px;
  logic [1:0]              s1_mode;
  logic s1_em1, s1_em2, s1_mt, s1_ml, s1_ml2, s1_mr, s1_last;
  logic                    s1_byp;
  logic [7:0]              byp_top;
  logic [7:0]              byp_mid;
  logic [7:0]              s1_top;
  logic [7:0]              s1_mid;

  logic [7:0]              up_q;
  logic [7:0]              mid_q;
  logic                    ram_we;

  logic [7:0] dl_u, dl_m, dc_u, dc_m;
  win_t       win;
  win_t       win_new;
  win_t       edge_win;
  win_t       flush_win;
  logic [7:0] code_main;
  logic [7:0] code_edge;
  logic [7:0] code_flush;

  oq_push_t         push;
  logic [OQ_CW-1:0] oq_count;

  assign cfg.ready = 1'b1;

  assign iw_ext = WW'(image_width);

  always_comb begin
    if (iw_ext == '0) begin
      w = CW'(1);
    end else if (iw_ext > WW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = iw_ext[CW-1:0];
    end
  end

  assign h        = (image_height == '0) ? CFG_HEIGHT_W'(1) : image_height;
  assign c        = ({1'b0, col_cnt} < w) ? col_cnt : AW'(w - CW'(1));
  assign r        = (row_cnt < h) ? row_cnt : h - CFG_HEIGHT_W'(1);
  assign lastc    = ({1'b0, c} == w - CW'(1));
  assign lastr    = (r == h - CFG_HEIGHT_W'(1));
  assign dc_clamp = (drain_cnt > w) ? w : drain_cnt;
  assign cc_full  = w - dc_clamp;
  assign cc_plus  = cc_full + CW'(1);
  assign cc_minus = cc_full - CW'(1);
  assign ml_f     = (cc_full == '0);
  assign mr_f     = (cc_plus >= w);

  assign is_flush     = (pix_in.req_type == REQ_FLUSH);
  assign drain_active = (drain_cnt != '0) && (border_mode != MODE_CROP);
  assign win_hit      = dwin_valid && (dwin_cc == cc_full);
  assign need_fill    = pix_in.valid && is_flush && drain_active && !win_hit;
  assign start_fill   = (st == ST_IDLE) && need_fill && !s1_valid;

  assign occ          = {1'b0, oq_count} + (s1_valid ? (OQ_CW + 1)'(2) : '0);
  assign room         = (occ <= (OQ_CW + 1)'(OQ_DEPTH - 2));
  assign pix_in.ready = room && (st == ST_IDLE) && !need_fill;
  assign acc          = pix_in.valid && pix_in.ready;

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE:   if (start_fill) st_next = ST_LEFT;
      ST_LEFT:   st_next = ST_CENTER;
      ST_CENTER: st_next = ST_IDLE;
      default:   st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = c;
    case (st)
      ST_LEFT: rd_addr = load_cc[AW-1:0];
      ST_IDLE: begin
        if (start_fill) begin
          rd_addr = ml_f ? cc_full[AW-1:0] : cc_minus[AW-1:0];
        end else if (acc && is_flush) begin
          rd_addr = mr_f ? cc_full[AW-1:0] : cc_plus[AW-1:0];
        end
      end
      default: rd_addr = c;
    endcase
  end

  always_comb begin
    s0_em1  = 1'b0;
    s0_em2  = 1'b0;
    s0_mt   = 1'b0;
    s0_ml   = 1'b0;
    s0_ml2  = 1'b0;
    s0_mr   = 1'b0;
    s0_last = 1'b0;
    if (is_flush) begin
      s0_em1  = drain_active;
      s0_mt   = (h == CFG_HEIGHT_W'(1));
      s0_ml   = ml_f;
      s0_mr   = mr_f;
      s0_last = (dc_clamp == CW'(1));
    end else if (border_mode == MODE_CROP) begin
      s0_em1  = (r >= CFG_HEIGHT_W'(2)) && (c >= AW'(2));
      s0_last = lastc && lastr;
    end else if (r != '0) begin
      s0_em1 = (c != '0);
      s0_em2 = lastc;
      s0_mt  = (r == CFG_HEIGHT_W'(1));
      s0_ml  = (c == AW'(1));
      s0_ml2 = (c == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_W'(640);
      image_height <= CFG_HEIGHT_W'(480);
      border_mode  <= MODE_CROP;
      col_cnt      <= '0;
      row_cnt      <= '0;
      drain_cnt    <= '0;
      st           <= ST_IDLE;
      s1_valid     <= 1'b0;
      dwin_valid   <= 1'b0;
      dwin_cc      <= '0;
    end else begin
      st       <= st_next;
      s1_valid <= acc;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:  image_width  <= cfg.data[CFG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg.data[CFG_HEIGHT_W-1:0];
          REG_BORDER_MODE:  border_mode  <= cfg.data[1:0];
          default: ;
        endcase
      end
      if (st == ST_CENTER) begin
        dwin_valid <= 1'b1;
        dwin_cc    <= load_cc;
      end
      if (acc) begin
        if (is_flush) begin
          if (drain_cnt != '0) begin
            if (border_mode == MODE_CROP) begin
              drain_cnt <= '0;
            end else begin
              drain_cnt <= dc_clamp - CW'(1);
              dwin_cc   <= cc_plus;
            end
          end
        end else begin
          dwin_valid <= 1'b0;
          drain_cnt  <= '0;
          if (lastc) begin
            col_cnt <= '0;
            if (lastr) begin
              row_cnt <= '0;
              if (border_mode != MODE_CROP) drain_cnt <= w;
            end else begin
              row_cnt <= r + CFG_HEIGHT_W'(1);
            end
          end else begin
            col_cnt <= c + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_fill) load_cc <= cc_full;
    if (acc) begin
      s1_is_pix <= !is_flush;
      s1_c      <= c;
      s1_px     <= pix_in.pixel;
      s1_mode   <= border_mode;
      s1_em1    <= s0_em1;
      s1_em2    <= s0_em2;
      s1_mt     <= s0_mt;
      s1_ml     <= s0_ml;
      s1_ml2    <= s0_ml2;
      s1_mr     <= s0_mr;
      s1_last   <= s0_last;
      s1_byp    <= !is_flush && s1_valid && s1_is_pix && (s1_c == c);
      byp_top   <= s1_mid;
      byp_mid   <= s1_px;
    end
  end

  assign s1_top = s1_byp ? byp_top : up_q;
  assign s1_mid = s1_byp ? byp_mid : mid_q;
  assign ram_we = s1_valid && s1_is_pix;

  lbp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_c),
    .wdata (s1_mid),
    .raddr (rd_addr),
    .rdata (up_q)
  );

  lbp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_c),
    .wdata (s1_px),
    .raddr (rd_addr),
    .rdata (mid_q)
  );

  always_ff @(posedge clk) begin
    if (st == ST_LEFT) begin
      dl_u <= up_q;
      dl_m <= mid_q;
    end else if (st == ST_CENTER) begin
      dc_u <= up_q;
      dc_m <= mid_q;
    end else if (s1_valid && !s1_is_pix && s1_em1) begin
      dl_u <= dc_u;
      dl_m <= dc_m;
      dc_u <= up_q;
      dc_m <= mid_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_new[k * 3]     = win[k * 3 + 1];
      win_new[k * 3 + 1] = win[k * 3 + 2];
    end
    win_new[2] = s1_top;
    win_new[5] = s1_mid;
    win_new[8] = s1_px;
    for (int k = 0; k < 3; k++) begin
      edge_win[k * 3]     = win_new[k * 3 + 1];
      edge_win[k * 3 + 1] = win_new[k * 3 + 2];
      edge_win[k * 3 + 2] = '0;
    end
  end

  always_comb begin
    flush_win    = '0;
    flush_win[0] = dl_u;
    flush_win[1] = dc_u;
    flush_win[2] = up_q;
    flush_win[3] = dl_m;
    flush_win[4] = dc_m;
    flush_win[5] = mid_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid && s1_is_pix) begin
      win <= win_new;
    end
  end

  assign code_main  = lbp_code(win_new, s1_mode, s1_mt, 1'b0, s1_ml, 1'b0);
  assign code_edge  = lbp_code(edge_win, s1_mode, s1_mt, 1'b0, s1_ml2, 1'b1);
  assign code_flush = lbp_code(flush_win, s1_mode, s1_mt, 1'b1, s1_ml, s1_mr);

  always_comb begin
    push = '0;
    if (s1_valid) begin
      if (s1_is_pix) begin
        push.first_v                = s1_em1 | s1_em2;
        push.second_v               = s1_em1 & s1_em2;
        push.first.code             = s1_em1 ? code_main : code_edge;
        push.first.last_of_frame    = s1_em1 & s1_last;
        push.second.code            = code_edge;
        push.second.last_of_frame   = 1'b0;
      end else begin
        push.first_v                = s1_em1;
        push.first.code             = code_flush;
        push.first.last_of_frame    = s1_last;
      end
    end
  end

  lbp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .q_out (code_out),
    .count (oq_count)
  );

  `LBP_ASSERT(a_fill_blocks_input, clk, rst, (st != ST_IDLE) |-> !pix_in.ready, "item taken during column fill")
  `LBP_ASSERT(a_fill_no_write, clk, rst, (st != ST_IDLE) |-> !ram_we, "line write during column fill")
  `LBP_ASSERT(a_queue_room, clk, rst, s1_valid |-> (oq_count <= OQ_CW'(OQ_DEPTH - 2)), "queue lacks room")
  `LBP_ASSERT(a_flush_window, clk, rst, (s1_valid && !s1_is_pix && s1_em1) |-> dwin_valid, "flush code without window")
  `LBP_ASSERT_NEXT(a_fill_done, clk, rst, st == ST_CENTER, dwin_valid, "fill did not mark window valid")

endmodule
